### rtl/stkc_pkg.sv
`default_nettype none
package stkc_pkg;

  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;
  localparam logic [2:0] ACT_NEG  = 3'd5;
  localparam logic [2:0] ACT_RET  = 3'd6;

  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_PUSH = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_NEG  = 3'd6;
  localparam logic [2:0] OP_RET  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] constant_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic               returned;
    logic [8:0]         depth;
  } out_word_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/stkc_ram.sv
`default_nettype none
module stkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/stkc_front.sv
`default_nettype none
module stkc_front
  import stkc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.value = in_word.constant_value;
    case (in_word.action)
      ACT_PUSH: cls.op = OP_PUSH;
      ACT_ADD:  cls.op = OP_ADD;
      ACT_SUB:  cls.op = OP_SUB;
      ACT_MUL:  cls.op = OP_MUL;
      ACT_DIV:  cls.op = OP_DIV;
      ACT_NEG:  cls.op = OP_NEG;
      ACT_RET:  cls.op = OP_RET;
      default:  cls.op = OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

### rtl/stkc_exec.sv
`default_nettype none
module stkc_exec
  import stkc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_word_t out_word
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DWB  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic signed [31:0] tos_r, tos_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               ret_r, ret_nxt;
  logic signed [31:0] retv_r, retv_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [47:0]        dvd_r, dvd_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        rdata;
  logic signed [31:0] opa;
  logic [SP_W-1:0]    spm1, spm2;
  logic [31:0]        amag;
  logic [32:0]        st1, st2;
  logic [47:0]        d1;
  logic signed [63:0] qext;

  stkc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (tos_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [32:0] div_bit(input logic [31:0] rem, input logic nb,
                                          input logic [31:0] dvs);
    logic [32:0] t;
    logic        q;
    t = {rem, nb};
    q = (t >= {1'b0, dvs});
    if (q) begin
      t = t - {1'b0, dvs};
    end
    return {q, t[31:0]};
  endfunction

  assign spm1      = sp_r - SP_W'(1);
  assign spm2      = sp_r - SP_W'(2);
  assign waddr     = spm1[AW-1:0];
  assign raddr     = spm2[AW-1:0];
  assign opa       = rdata;
  assign amag      = opa[31] ? 32'(-opa) : 32'(opa);
  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    st1  = div_bit(rem_r, dvd_r[47], dvs_r);
    d1   = {dvd_r[46:0], st1[32]};
    st2  = div_bit(st1[31:0], d1[47], dvs_r);
    qext = $signed({16'b0, dvd_r});
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    ret_nxt       = ret_r;
    retv_nxt      = retv_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    we            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt     = cmd.op;
          status_nxt = ST_OK;
          ret_nxt    = 1'b0;
          state_nxt  = S_FIN;
          case (cmd.op)
            OP_PUSH: begin
              if (sp_r == SP_W'(STACK_DEPTH)) begin
                status_nxt = ST_OVER;
              end else begin
                we      = (sp_r != '0);
                tos_nxt = cmd.value;
                sp_nxt  = sp_r + SP_W'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp_r < SP_W'(2)) begin
                status_nxt = ST_UNDER;
              end else if (cmd.op == OP_DIV && tos_r == '0) begin
                status_nxt = ST_DIVZERO;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_NEG: begin
              if (sp_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                tos_nxt = sat64(-(64'(tos_r)));
              end
            end
            OP_RET: begin
              if (sp_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                ret_nxt  = 1'b1;
                retv_nxt = tos_r;
                sp_nxt   = spm1;
                if (sp_r >= SP_W'(2)) begin
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_ADD: begin
            tos_nxt = sat64(64'(opa) + 64'(tos_r));
            sp_nxt  = spm1;
          end
          OP_SUB: begin
            tos_nxt = sat64(64'(opa) - 64'(tos_r));
            sp_nxt  = spm1;
          end
          OP_MUL: begin
            prod_nxt  = opa * tos_r;
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            neg_nxt   = opa[31] ^ tos_r[31];
            dvd_nxt   = {amag, 16'b0};
            rem_nxt   = '0;
            dvs_nxt   = tos_r[31] ? 32'(-tos_r) : 32'(tos_r);
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
          default: begin
            tos_nxt = opa;
          end
        endcase
      end
      S_MUL: begin
        tos_nxt   = sat64(prod_r >>> 16);
        sp_nxt    = spm1;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        dvd_nxt = {d1[46:0], st2[32]};
        rem_nxt = st2[31:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          state_nxt = S_DWB;
        end
      end
      S_DWB: begin
        tos_nxt   = neg_r ? sat64(-qext) : sat64(qext);
        sp_nxt    = spm1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = status_r;
          out_nxt.returned  = ret_r;
          out_nxt.depth     = 9'(sp_r);
          out_nxt.top_value = ret_r ? retv_r : ((sp_r == '0) ? 32'sd0 : tos_r);
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r    <= tos_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    ret_r    <= ret_nxt;
    retv_r   <= retv_nxt;
    prod_r   <= prod_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    out_r    <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_div_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_DWB) |-> op_r == OP_DIV)
    else $error("divider running for another operation");

  a_ret_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.returned) |-> out_r.status == ST_OK)
    else $error("returned word with fault status");

  a_add_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && (op_r == OP_ADD || op_r == OP_SUB)) |=> state_r == S_FIN)
    else $error("add or subtract did not finish after operand read");
`endif

endmodule
`default_nettype wire

### rtl/stack_bytecode_calculator_unit.sv
// One word is worked on at a time. Push, negate, no-op and any fault go from idle straight
// to the finish state; add, subtract and a return that leaves a value first read the operand
// from the stack memory, multiply then adds a multiply state, and divide runs 24 steps of
// two quotient bits each and a write-back; the two-entry queue keeps taking input meanwhile.
// Reset (rst_n low, synchronous) empties the stack and the queue; memory contents are kept.
`default_nettype none
module stack_bytecode_calculator_unit
  import stkc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  stkc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  stkc_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
